>>> design/ams_pkg.sv
// Package: widths, opcodes, commands, status codes and sequencer states.
`default_nettype none
package ams_pkg;
	localparam int MemoryWords = 100;
	localparam int StackDepth  = 30;
	localparam int AccBits     = 32;
	localparam int MemAw       = $clog2(MemoryWords);
	localparam int SpW         = $clog2(StackDepth + 1);
	localparam int StkAw       = $clog2(StackDepth);
	localparam int CntW        = $clog2(AccBits + 1);

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_START = 2'd2,
		CMD_STEP  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_HALTED = 3'd1,
		ST_OVER   = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_DIVZ   = 3'd4,
		ST_STOP   = 3'd5
	} status_t;

	localparam logic [7:0] OP_PRINT = 8'h11;
	localparam logic [7:0] OP_LOAD  = 8'h20;
	localparam logic [7:0] OP_STORE = 8'h21;
	localparam logic [7:0] OP_SET   = 8'h22;
	localparam logic [7:0] OP_ADD   = 8'h30;
	localparam logic [7:0] OP_SUB   = 8'h31;
	localparam logic [7:0] OP_MUL   = 8'h32;
	localparam logic [7:0] OP_DIV   = 8'h33;
	localparam logic [7:0] OP_MOD   = 8'h34;
	localparam logic [7:0] OP_INC   = 8'h35;
	localparam logic [7:0] OP_DEC   = 8'h36;
	localparam logic [7:0] OP_NEG   = 8'h37;
	localparam logic [7:0] OP_JMP   = 8'h40;
	localparam logic [7:0] OP_JNEG  = 8'h41;
	localparam logic [7:0] OP_JZERO = 8'h42;
	localparam logic [7:0] OP_HALT  = 8'h43;
	localparam logic [7:0] OP_AND   = 8'h50;
	localparam logic [7:0] OP_OR    = 8'h51;
	localparam logic [7:0] OP_XOR   = 8'h52;
	localparam logic [7:0] OP_PUSH  = 8'h60;
	localparam logic [7:0] OP_POP   = 8'h61;
	localparam logic [7:0] OP_CPA   = 8'h62;
	localparam logic [7:0] OP_CPB   = 8'h63;
	localparam logic [7:0] OP_CPC   = 8'h64;
	localparam logic [7:0] OP_CPD   = 8'h65;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_FETCH, S_DEC, S_OPRD, S_EXEC,
		S_MUL, S_DIV, S_FIN, S_POP, S_OUT
	} state_t;

	// Request to and answer from the iterative mul/div unit
	typedef struct packed {
		logic start;
		logic is_div;
		logic [AccBits-1:0] a;
		logic [AccBits-1:0] b;
	} md_req_t;

	typedef struct packed {
		logic done;
		logic [AccBits-1:0] prod;
		logic [AccBits-1:0] quot;
		logic [AccBits-1:0] rem;
	} md_rsp_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        running;
		logic        print_valid;
		logic [15:0] print_value;
		logic [31:0] accumulator;
		logic [31:0] instruction_count;
		logic [7:0]  byte_reg_a;
		logic [7:0]  byte_reg_b;
		logic [7:0]  byte_reg_c;
		logic [7:0]  byte_reg_d;
	} result_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [6:0]  address;
		logic [15:0] word;
	} item_t;
endpackage
`default_nettype wire

>>> design/ams_stream_if.sv
// Valid/ready channel carrying one payload word.
`default_nettype none
interface ams_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/ams_muldiv.sv
// Shared iterative unit: shift-add multiply and restoring unsigned divide.
`default_nettype none
module ams_muldiv (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ams_pkg::md_req_t req,
	output ams_pkg::md_rsp_t      rsp
);
	import ams_pkg::*;

	logic [AccBits-1:0] a_q, b_q, acc_q, rem_q;
	logic [CntW-1:0]    cnt_q;
	logic               busy_q, div_q, done_q;
	logic [AccBits:0]   trial;
	logic [AccBits-1:0] rsh;

	// one bit per cycle: remainder shift and trial subtraction for divide
	assign rsh   = {rem_q[AccBits-2:0], a_q[AccBits-1]};
	assign trial = {1'b0, rsh} - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(AccBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			div_q <= req.is_div;
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				a_q <= {a_q[AccBits-2:0], ~trial[AccBits]};
				rem_q <= trial[AccBits] ? rsh : trial[AccBits-1:0];
			end else begin
				if (b_q[0]) acc_q <= acc_q + a_q;
				a_q <= {a_q[AccBits-2:0], 1'b0};
				b_q <= {1'b0, b_q[AccBits-1:1]};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;
	assign rsp.quot = a_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

>>> design/accumulator_machine_step_unit.sv
// Top level: command decode, memory, stack and instruction sequencer.
// A step runs fetch, decode, operand read and execute, then multiply/divide or pop
// if needed, then finish and output; with the counter past memory it halts at fetch.
// One command at a time; in_ch.ready is low until the result word is taken.
// Reset clears the machine state; the memory is swept to zero after reset
// (no result word) before the first command is taken.
`default_nettype none
module accumulator_machine_step_unit (
	input wire logic clk,
	input wire logic arst_n,
	ams_stream_if.sink   in_ch,
	ams_stream_if.source out_ch
);
	import ams_pkg::*;

	state_t state_q, state_d;
	logic [15:0] mem [MemoryWords];
	logic [15:0] stk [StackDepth];
	logic [15:0] rd_q, stk_rd_q;
	logic [AccBits-1:0] acc_q;
	logic [MemAw-1:0] clr_q;
	logic boot_q;
	logic [7:0] pc_q;
	logic [SpW-1:0] sp_q;
	logic [31:0] cnt_q;
	logic run_q, pv_q;
	logic [15:0] pval_q;
	logic [2:0] st_q;
	logic [7:0] bytes_q [4];
	logic [15:0] insn_q;
	logic [7:0] rd_addr;
	md_req_t mreq;
	md_rsp_t mrsp;
	logic [AccBits-1:0] a_mag, b_mag, bw;
	logic a_neg, b_neg;
	logic [7:0] op, opd;

	assign op  = insn_q[15:8];
	assign opd = insn_q[7:0];
	assign bw  = AccBits'(signed'(rd_q));
	assign a_neg = acc_q[AccBits-1];
	assign b_neg = rd_q[15];
	assign a_mag = a_neg ? -acc_q : acc_q;
	assign b_mag = b_neg ? -bw : bw;

	ams_muldiv u_md (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_ch.valid) begin
				unique case (cmd_t'(in_ch.data.command))
					CMD_CLEAR: state_d = S_CLEAR;
					CMD_STEP:  state_d = run_q ? S_FETCH : S_OUT;
					default:   state_d = S_OUT;
				endcase
			end
			// the sweep after reset answers nothing
			S_CLEAR: if (clr_q == MemAw'(MemoryWords - 1)) state_d = boot_q ? S_IDLE : S_OUT;
			S_FETCH: state_d = (pc_q >= 8'(MemoryWords)) ? S_OUT : S_DEC;
			S_DEC:   state_d = S_OPRD;
			S_OPRD:  state_d = S_EXEC;
			S_EXEC: begin
				if (op == OP_MUL) state_d = S_MUL;
				else if ((op == OP_DIV || op == OP_MOD) && rd_q != 16'd0) state_d = S_DIV;
				else if (op == OP_POP) state_d = S_POP;
				else state_d = S_FIN;
			end
			S_MUL, S_DIV: if (mrsp.done) state_d = S_FIN;
			S_POP:   state_d = S_FIN;
			S_FIN:   state_d = S_OUT;
			S_OUT:   if (out_ch.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ch.ready  = (state_q == S_IDLE);
		out_ch.valid = (state_q == S_OUT);
		mreq.start   = (state_q == S_EXEC) &&
			(op == OP_MUL || ((op == OP_DIV || op == OP_MOD) && rd_q != 16'd0));
		mreq.is_div  = (op != OP_MUL);
		mreq.a       = (op == OP_MUL) ? acc_q : a_mag;
		mreq.b       = (op == OP_MUL) ? bw : b_mag;
		rd_addr      = (state_q == S_FETCH) ? pc_q : opd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	// memory: read registered, sweep on clear
	always_ff @(posedge clk) begin
		rd_q <= (rd_addr < 8'(MemoryWords)) ? mem[rd_addr[MemAw-1:0]] : 16'd0;
		if (state_q == S_CLEAR) mem[clr_q] <= 16'd0;
		else if (state_q == S_IDLE && in_ch.valid && in_ch.data.command == CMD_WRITE &&
			in_ch.data.address < 7'(MemoryWords))
			mem[in_ch.data.address[MemAw-1:0]] <= in_ch.data.word;
		else if (state_q == S_EXEC && opd < 8'(MemoryWords)) begin
			if (op == OP_STORE) mem[opd[MemAw-1:0]] <= acc_q[15:0];
			else if (op == OP_INC) mem[opd[MemAw-1:0]] <= rd_q + 16'd1;
			else if (op == OP_DEC) mem[opd[MemAw-1:0]] <= rd_q - 16'd1;
			else if (op == OP_NEG) mem[opd[MemAw-1:0]] <= -rd_q;
		end
	end

	// stack store
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && op == OP_PUSH && sp_q < SpW'(StackDepth))
			stk[sp_q[StkAw-1:0]] <= acc_q[15:0];
		if (state_q == S_EXEC) stk_rd_q <= stk[StkAw'(sp_q - 1'b1)];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DEC) insn_q <= rd_q;
	end

	// machine registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; pc_q <= '0; sp_q <= '0; cnt_q <= '0; run_q <= 1'b0;
			pv_q <= 1'b0; pval_q <= '0; st_q <= ST_OK; clr_q <= '0; boot_q <= 1'b1;
			for (int i = 0; i < 4; i++) bytes_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					pv_q <= 1'b0; pval_q <= '0; st_q <= ST_OK; clr_q <= '0;
					if (in_ch.valid) begin
						if (in_ch.data.command == CMD_START) run_q <= 1'b1;
						if (in_ch.data.command == CMD_STEP && !run_q) st_q <= ST_STOP;
						if (in_ch.data.command == CMD_CLEAR) begin
							pc_q <= '0; sp_q <= '0; cnt_q <= '0;
						end
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MemAw'(MemoryWords - 1)) boot_q <= 1'b0;
				end
				S_FETCH: if (pc_q >= 8'(MemoryWords)) begin
					run_q <= 1'b0; st_q <= ST_HALTED;
				end
				S_EXEC: begin
					cnt_q <= cnt_q + 1'b1;
					pc_q  <= pc_q + 1'b1;
					unique case (op)
						OP_PRINT: begin pv_q <= 1'b1; pval_q <= rd_q; end
						OP_LOAD: acc_q <= bw;
						OP_SET:  acc_q <= AccBits'(opd);
						OP_ADD:  acc_q <= acc_q + bw;
						OP_SUB:  acc_q <= acc_q - bw;
						OP_DIV, OP_MOD: if (rd_q == 16'd0) st_q <= ST_DIVZ;
						OP_JMP:  pc_q <= opd;
						OP_JNEG: if (a_neg) pc_q <= opd;
						OP_JZERO: if (acc_q == '0) pc_q <= opd;
						OP_HALT: begin pc_q <= pc_q; run_q <= 1'b0; st_q <= ST_HALTED; end
						OP_AND:  acc_q <= acc_q & bw;
						OP_OR:   acc_q <= acc_q | bw;
						OP_XOR:  acc_q <= acc_q ^ bw;
						OP_PUSH: if (sp_q < SpW'(StackDepth)) sp_q <= sp_q + 1'b1;
							else st_q <= ST_OVER;
						OP_POP:  if (sp_q == '0 || sp_q > SpW'(StackDepth)) st_q <= ST_EMPTY;
						OP_CPA, OP_CPB, OP_CPC, OP_CPD: bytes_q[op[1:0] - 2'd2] <= acc_q[7:0];
						default: ;
					endcase
				end
				S_MUL: if (mrsp.done) acc_q <= mrsp.prod;
				S_DIV: if (mrsp.done) begin
					if (op == OP_DIV) acc_q <= (a_neg != b_neg) ? -mrsp.quot : mrsp.quot;
					else acc_q <= a_neg ? -mrsp.rem : mrsp.rem;
				end
				S_POP: if (st_q == ST_OK) begin
					acc_q <= AccBits'(signed'(stk_rd_q)); sp_q <= sp_q - 1'b1;
				end
				S_FIN: if (op != OP_HALT && pc_q >= 8'(MemoryWords)) begin
					run_q <= 1'b0;
					if (st_q == ST_OK) st_q <= ST_HALTED;
				end
				default: ;
			endcase
		end
	end

	assign out_ch.data.status            = st_q;
	assign out_ch.data.running           = run_q;
	assign out_ch.data.print_valid       = pv_q;
	assign out_ch.data.print_value       = pval_q;
	assign out_ch.data.accumulator       = 32'(signed'(acc_q));
	assign out_ch.data.instruction_count = cnt_q;
	assign out_ch.data.byte_reg_a        = bytes_q[0];
	assign out_ch.data.byte_reg_b        = bytes_q[1];
	assign out_ch.data.byte_reg_c        = bytes_q[2];
	assign out_ch.data.byte_reg_d        = bytes_q[3];
endmodule
`default_nettype wire
